FILE: src/cuwt_pkg.sv
// Shared types and constants for the card identifier whitelist table.
package cuwt_pkg;

  localparam int MAX_ENTRIES = 20;
  localparam int UID_BITS    = 32;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [UID_BITS-1:0] MASTER_RESET = UID_BITS'(32'hD948CA06);

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REVOKE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                shift_en;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_slot;
    logic [UID_BITS-1:0] wr_data;
  } cell_ctl_t;

endpackage

FILE: src/card_uid_whitelist_table_top.sv
// Top level of the card identifier whitelist table: identifier ring and sequencer.
//
//   channel  direction  signals
//   in       input      in_valid/in_ready, in_opcode, in_uid
//   out      output     out_valid/out_ready, out_success, out_status,
//                       out_is_master, out_entry_count_out
//   cfg      input      cfg_valid/cfg_ready, cfg_data (master identifier)
//
// Each accepted transaction steps through every slot of the ring in S_SCAN, then its result is registered in S_FINISH.
// The next transaction can be accepted in the same cycle that this result appears in the output register.
// The entries rotate once around the cell ring, one slot per cycle past the compare at the head.
// Reset clears the entry count and loads the default master identifier.
// A new transaction is accepted while the previous result waits in the output register.
// A stalled output holds the sequencer in its final step until the result is taken.
module card_uid_whitelist_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [cuwt_pkg::UID_BITS-1:0] in_uid,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cuwt_pkg::UID_BITS-1:0] cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_success,
  output logic [1:0]                    out_status,
  output logic                          out_is_master,
  output logic [cuwt_pkg::CNT_W-1:0]    out_entry_count_out
);
  import cuwt_pkg::*;

  cell_ctl_t           cell_ctl;
  logic [UID_BITS-1:0] ring_uid [MAX_ENTRIES];

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    cuwt_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .slot_id (IDX_W'(k)),
      .nbr_uid (ring_uid[(k + 1) % MAX_ENTRIES]),
      .uid     (ring_uid[k])
    );
  end

  cuwt_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_uid              (in_uid),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_success         (out_success),
    .out_status          (out_status),
    .out_is_master       (out_is_master),
    .out_entry_count_out (out_entry_count_out),
    .head_uid            (ring_uid[0]),
    .cell_ctl            (cell_ctl)
  );

endmodule

FILE: src/cuwt_cell.sv
// One storage cell of the rotating identifier ring.
module cuwt_cell (
  input  logic                          clk,
  input  cuwt_pkg::cell_ctl_t           ctl,
  input  logic [cuwt_pkg::IDX_W-1:0]    slot_id,
  input  logic [cuwt_pkg::UID_BITS-1:0] nbr_uid,
  output logic [cuwt_pkg::UID_BITS-1:0] uid
);
  import cuwt_pkg::*;

  logic [UID_BITS-1:0] uid_r;

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      uid_r <= nbr_uid;
    end else if (ctl.wr_en && (ctl.wr_slot == slot_id)) begin
      uid_r <= ctl.wr_data;
    end
  end

  assign uid = uid_r;

endmodule

FILE: src/cuwt_ctrl.sv
// Sequencer that scans the ring, decides each operation and holds the result.
module cuwt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [cuwt_pkg::UID_BITS-1:0] in_uid,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cuwt_pkg::UID_BITS-1:0] cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_success,
  output logic [1:0]                    out_status,
  output logic                          out_is_master,
  output logic [cuwt_pkg::CNT_W-1:0]    out_entry_count_out,
  input  logic [cuwt_pkg::UID_BITS-1:0] head_uid,
  output cuwt_pkg::cell_ctl_t           cell_ctl
);
  import cuwt_pkg::*;

  state_t              state_r, state_nxt;
  logic [1:0]          op_r;
  logic [UID_BITS-1:0] uid_r;
  logic [UID_BITS-1:0] master_r;
  logic                master_hit_r;
  logic [IDX_W-1:0]    idx_r;
  logic                hit_r;
  logic [IDX_W-1:0]    slot_r;
  logic [UID_BITS-1:0] last_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r;
  logic                out_success_r;
  logic [1:0]          out_status_r;
  logic                out_is_master_r;
  logic [CNT_W-1:0]    out_count_r;

  logic                accept;
  logic                scan_last;
  logic                in_range;
  logic                finish_fire;
  logic                ok;
  logic [1:0]          status;

  assign accept    = in_valid && in_ready;
  assign scan_last = (idx_r == IDX_W'(MAX_ENTRIES - 1));
  assign in_range  = (CNT_W'(idx_r) < count_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == S_IDLE);
    finish_fire = (state_r == S_FINISH) && (!out_valid_r || out_ready);
    ok          = 1'b0;
    status      = ST_OK;
    count_nxt   = count_r;
    cell_ctl.shift_en = (state_r == S_SCAN);
    cell_ctl.wr_en    = 1'b0;
    cell_ctl.wr_slot  = slot_r;
    cell_ctl.wr_data  = last_r;
    case (op_r)
      OP_ADD: begin
        if (count_r >= CNT_W'(MAX_ENTRIES)) begin
          status = ST_FULL;
        end else if (hit_r) begin
          status = ST_PRESENT;
        end else begin
          ok               = 1'b1;
          count_nxt        = count_r + CNT_W'(1);
          cell_ctl.wr_en   = finish_fire;
          cell_ctl.wr_slot = count_r[IDX_W-1:0];
          cell_ctl.wr_data = uid_r;
        end
      end
      OP_REVOKE: begin
        if (!hit_r) begin
          status = ST_ABSENT;
        end else begin
          ok             = 1'b1;
          count_nxt      = count_r - CNT_W'(1);
          cell_ctl.wr_en = finish_fire;
        end
      end
      default: begin
        ok     = hit_r;
        status = hit_r ? ST_OK : ST_ABSENT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      master_r    <= MASTER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        master_r <= cfg_data;
      end
      if (finish_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_opcode;
      uid_r        <= in_uid;
      master_hit_r <= (in_uid == master_r);
      idx_r        <= '0;
      hit_r        <= 1'b0;
    end else if (state_r == S_SCAN) begin
      if (in_range && (head_uid == uid_r) && !hit_r) begin
        hit_r  <= 1'b1;
        slot_r <= idx_r;
      end
      if (in_range && (CNT_W'(idx_r) == count_r - CNT_W'(1))) begin
        last_r <= head_uid;
      end
      if (!scan_last) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
    if (finish_fire) begin
      out_success_r   <= ok;
      out_status_r    <= status;
      out_is_master_r <= master_hit_r;
      out_count_r     <= count_nxt;
    end
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_success         = out_success_r;
  assign out_status          = out_status_r;
  assign out_is_master       = out_is_master_r;
  assign out_entry_count_out = out_count_r;

endmodule
